/* rtl/cfp_pkg.sv */
// Shared types, protocol constants and helper functions for the command
// frame parser with ack. No dependencies; imported by every module.
package cfp_pkg;

  // Frame bytes and commands
  localparam logic [7:0] HDR1     = 8'hAA;
  localparam logic [7:0] HDR2     = 8'h55;
  localparam logic [7:0] TAIL     = 8'h0D;
  localparam logic [7:0] ACK_LEN  = 8'h08;
  localparam logic [7:0] ACK_TYPE = 8'h0F;
  localparam logic [7:0] CMD_HALT = 8'h10;
  localparam logic [7:0] CMD_VOLT = 8'h11;
  localparam logic [7:0] CMD_TEMP = 8'h12;
  localparam logic [7:0] CMD_DUAL = 8'h13;
  localparam logic [7:0] LEN_MIN  = 8'h07;
  localparam logic [7:0] LEN_MAX  = 8'h09;
  localparam logic [7:0] ERR_CRC  = 8'h05;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Shortest frame that a tail byte may close
  localparam int MIN_FRAME_LEN = 7;
  // Only the first bytes of a frame are ever read back
  localparam int STORE_SLOTS = 8;
  localparam int SLOT_W = $clog2(STORE_SLOTS);

  // Result codes
  localparam logic [2:0] RC_OK   = 3'd0;
  localparam logic [2:0] RC_HDR  = 3'd1;
  localparam logic [2:0] RC_LEN  = 3'd2;
  localparam logic [2:0] RC_BUSY = 3'd3;
  localparam logic [2:0] RC_CRC  = 3'd4;

  // Modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_VOLT = 2'd1;
  localparam logic [1:0] MODE_TEMP = 2'd2;
  localparam logic [1:0] MODE_DUAL = 2'd3;

  // Control of the bit-serial CRC unit
  typedef struct packed {
    logic clear;
    logic shift;
    logic din;
  } crc_ctl_t;

  // Launch of one ack frame
  typedef struct packed {
    logic       start;
    logic [7:0] seq;
    logic [7:0] err;
    logic [7:0] crc;
  } ack_start_t;

  // Map a result code to the error byte of the ack frame
  function automatic logic [7:0] ack_err(input logic [2:0] code);
    logic [7:0] e;
    e = (code == RC_CRC) ? ERR_CRC : {5'b0, code};
    return e;
  endfunction

endpackage

/* rtl/cfp_crc8.sv */
// Bit-serial CRC8 (polynomial 0x07), one message bit per cycle while ctl.shift is set, MSB first.
// Depends on cfp_pkg for the control struct and polynomial.
module cfp_crc8 (
  input  logic              clk,
  input  logic              rst,
  input  cfp_pkg::crc_ctl_t ctl,
  output logic [7:0]        crc
);
  import cfp_pkg::*;

  logic fb;

  assign fb = crc[7] ^ ctl.din;

  // Clear, or fold in one bit
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 8'h00;
    end else if (ctl.clear) begin
      crc <= 8'h00;
    end else if (ctl.shift) begin
      crc <= {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
  end

endmodule

/* rtl/cfp_ack_tx.sv */
// Ack frame serializer: loads eight bytes and hands them out one item at a
// time through a 64-bit shift register that advances a byte per item. Depends on cfp_pkg.
module cfp_ack_tx (
  input  logic                clk,
  input  logic                rst,
  input  cfp_pkg::ack_start_t launch,
  input  logic                ack_ready,
  output logic                ack_valid,
  output logic [7:0]          out_byte,
  output logic                last_byte
);
  import cfp_pkg::*;

  logic [63:0] sreg;
  logic [2:0]  pos;

  assign out_byte  = sreg[63:56];
  assign last_byte = (pos == 3'd7);

  // Load the frame, then advance one byte per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (launch.start) begin
      sreg      <= {HDR1, HDR2, ACK_LEN, ACK_TYPE, launch.seq, launch.err,
                    launch.crc, TAIL};
      pos       <= 3'd0;
      ack_valid <= 1'b1;
    end else if (ack_valid && ack_ready) begin
      sreg <= {sreg[55:0], 8'h00};
      pos  <= pos + 3'd1;
      if (pos == 3'd7) begin
        ack_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/command_frame_parser_ack_core.sv */
// Top level of the command frame parser with ack: receive buffer, frame
// sequencer, decode and APB register. Uses cfp_pkg, cfp_crc8, cfp_ack_tx.
//
//  channel | direction | handshake            | payload
//  rx      | in        | rx_valid / rx_ready  | rx_byte
//  ack     | out       | ack_valid / ack_ready| out_byte, last_byte, status fields
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// A byte that does not close a frame is taken while rx_ready stays high.
// A closing byte starts the sequencer: header/length check, each covered
// byte through the bit-serial CRC unit (3 to 5 bytes), decode, the ack CRC
// over four bytes, then 8 ack items; a header or length failure skips the
// frame CRC and decode, and ack stalls hold the sequencer in ST_TX.
// rx_ready is low after the closing byte until ST_TX sees ack_valid drop after the last ack item.
// Synchronous reset restores the reset periods, idle mode and an empty store.
module command_frame_parser_ack_core #(
  parameter int BUF_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // receive bytes
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // ack items
  output logic        ack_valid,
  input  logic        ack_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic [2:0]  result_code,
  output logic [1:0]  mode_now,
  output logic [15:0] volt_period_ms,
  output logic [15:0] temp_period_ms,
  output logic [15:0] overflow_total
);
  import cfp_pkg::*;

  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(STORE_SLOTS);
  localparam logic [CNT_W-1:0] MINF_C  = CNT_W'(MIN_FRAME_LEN);
  localparam logic             REG_PERIOD_SCALE = 1'b0;

  typedef enum logic [3:0] {
    ST_RX, ST_HDR, ST_LOAD, ST_CRC, ST_EXEC, ST_PREP, ST_ACKCRC, ST_LAUNCH, ST_TX
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_inc;
  logic [7:0]        store [STORE_SLOTS];
  logic [7:0]        period_scale;
  logic [SLOT_W-1:0] idx;
  logic [4:0]        bitcnt;
  logic [31:0]       shreg;
  logic              crc_ok;
  logic [7:0]        crc;
  logic [15:0]       prod_p;
  logic [15:0]       prod_q;
  logic              cfg_wr;
  crc_ctl_t          crc_ctl;
  ack_start_t        launch;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_PERIOD_SCALE) ? {24'b0, period_scale} : 32'b0;

  assign rx_ready  = (state == ST_RX);
  assign count_inc = count + CNT_W'(1);

  // Period products for start commands
  assign prod_p = {8'b0, store[5]} * {8'b0, period_scale};
  assign prod_q = {8'b0, store[6]} * {8'b0, period_scale};

  // Drive the serial CRC unit and the ack launch
  always_comb begin
    crc_ctl.clear = (state == ST_HDR) || (state == ST_PREP);
    crc_ctl.shift = (state == ST_CRC) || (state == ST_ACKCRC);
    crc_ctl.din   = shreg[31];
    launch.start  = (state == ST_LAUNCH);
    launch.seq    = store[4];
    launch.err    = ack_err(result_code);
    launch.crc    = crc;
  end

  cfp_crc8 u_crc (
    .clk (clk),
    .rst (rst),
    .ctl (crc_ctl),
    .crc (crc)
  );

  cfp_ack_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .launch    (launch),
    .ack_ready (ack_ready),
    .ack_valid (ack_valid),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  // Frame sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RX;
      count          <= '0;
      idx            <= '0;
      bitcnt         <= 5'd0;
      crc_ok         <= 1'b0;
      result_code    <= RC_OK;
      mode_now       <= MODE_IDLE;
      volt_period_ms <= 16'd50;
      temp_period_ms <= 16'd50;
      overflow_total <= 16'd0;
      period_scale   <= 8'd5;
      for (int i = 0; i < STORE_SLOTS; i++) begin
        store[i] <= 8'h00;
      end
    end else begin
      if (cfg_wr && paddr[2] == REG_PERIOD_SCALE) begin
        period_scale <= pwdata[7:0];
      end
      unique case (state)
        ST_RX: begin
          if (rx_valid) begin
            priority if (count >= DEPTH_C) begin
              // drop the byte, restart sync
              count <= '0;
              if (overflow_total != 16'hFFFF) begin
                overflow_total <= overflow_total + 16'd1;
              end
            end else if (count == CNT_W'(0)) begin
              if (rx_byte == HDR1) begin
                store[0] <= rx_byte;
                count    <= count_inc;
              end
            end else if (count == CNT_W'(1)) begin
              if (rx_byte == HDR2) begin
                store[1] <= rx_byte;
                count    <= count_inc;
              end else begin
                count <= '0;
              end
            end else begin
              if (count < SLOTS_C) begin
                store[count[SLOT_W-1:0]] <= rx_byte;
              end
              count <= count_inc;
              if (count_inc >= MINF_C && rx_byte == TAIL) begin
                state <= ST_HDR;
              end
            end
          end
        end
        ST_HDR: begin
          idx <= SLOT_W'(2);
          if (store[0] != HDR1 || store[1] != HDR2) begin
            result_code <= RC_HDR;
            state       <= ST_PREP;
          end else if (store[2] < LEN_MIN || store[2] > LEN_MAX) begin
            result_code <= RC_LEN;
            state       <= ST_PREP;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          bitcnt <= 5'd0;
          // the byte after the covered range holds the frame CRC
          if ({{(8 - SLOT_W){1'b0}}, idx} == store[2] - 8'd2) begin
            crc_ok <= (store[idx] == crc);
            state  <= ST_EXEC;
          end else begin
            shreg <= {store[idx], 24'b0};
            state <= ST_CRC;
          end
        end
        ST_CRC: begin
          shreg  <= {shreg[30:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt[2:0] == 3'd7) begin
            idx   <= idx + SLOT_W'(1);
            state <= ST_LOAD;
          end
        end
        ST_EXEC: begin
          state <= ST_PREP;
          if (!crc_ok) begin
            result_code <= RC_CRC;
          end else if (mode_now != MODE_IDLE && store[3] != CMD_HALT) begin
            result_code <= RC_BUSY;
          end else begin
            unique case (store[3])
              CMD_HALT: begin
                mode_now    <= MODE_IDLE;
                result_code <= RC_OK;
              end
              CMD_VOLT: begin
                if (store[5] == 8'h00) begin
                  result_code <= RC_LEN;
                end else begin
                  volt_period_ms <= prod_p;
                  mode_now       <= MODE_VOLT;
                  result_code    <= RC_OK;
                end
              end
              CMD_TEMP: begin
                if (store[5] == 8'h00) begin
                  result_code <= RC_LEN;
                end else begin
                  temp_period_ms <= prod_p;
                  mode_now       <= MODE_TEMP;
                  result_code    <= RC_OK;
                end
              end
              CMD_DUAL: begin
                if (store[5] == 8'h00 || store[6] == 8'h00) begin
                  result_code <= RC_LEN;
                end else begin
                  volt_period_ms <= prod_p;
                  temp_period_ms <= prod_q;
                  mode_now       <= MODE_DUAL;
                  result_code    <= RC_OK;
                end
              end
              default: begin
                result_code <= RC_HDR;
              end
            endcase
          end
        end
        ST_PREP: begin
          shreg  <= {ACK_LEN, ACK_TYPE, store[4], ack_err(result_code)};
          bitcnt <= 5'd0;
          state  <= ST_ACKCRC;
        end
        ST_ACKCRC: begin
          shreg  <= {shreg[30:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'd31) begin
            state <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          // empty the buffer as the ack goes out
          count <= '0;
          for (int i = 0; i < STORE_SLOTS; i++) begin
            store[i] <= 8'h00;
          end
          state <= ST_TX;
        end
        ST_TX: begin
          if (!ack_valid) begin
            state <= ST_RX;
          end
        end
        default: begin
          state <= ST_RX;
        end
      endcase
    end
  end

  // No byte is taken while an ack frame is pending
  a_rx_blocked: assert property (@(posedge clk) disable iff (rst)
    ack_valid |-> !rx_ready)
    else $error("rx byte taken during ack");

  // The final ack item ends the frame
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (ack_valid && ack_ready && last_byte) |=> !ack_valid)
    else $error("ack continues after last byte");

  // Fill count never passes the buffer depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("byte count beyond depth");

  // Overflow total never falls
  a_ovf_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> overflow_total >= $past(overflow_total))
    else $error("overflow total decreased");

endmodule
